// ===== src/assert_macros.svh =====
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CHK_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: check failed");

// Condition that implies a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Implication that is not disabled by reset, so it is also checked while in reset.
`define CHK_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

// ===== src/b64e_pkg.sv =====
`default_nettype none
package b64e_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [1:0] CFG_LINE_QUADS    = 2'd0;
  localparam logic [1:0] CFG_INDENT_SPACES = 2'd1;

  localparam logic [5:0] LINE_QUADS_RST    = 6'd16;
  localparam logic [3:0] INDENT_SPACES_RST = 4'd4;
  localparam logic [3:0] INDENT_CAP        = 4'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_text;
  } out_item_t;

  // one request from the front to the back
  typedef struct packed {
    logic        has_group;
    logic        line_break;
    logic [2:0]  spaces;
    logic [23:0] triplet;
    logic [1:0]  nbytes;
    logic        close;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)       c = 8'h41 + {2'b00, v};
    else if (v < 6'd52)  c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62)  c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = CHAR_PLUS;
    else                 c = CHAR_SLASH;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/b64e_front.sv =====
`default_nettype none
module b64e_front import b64e_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data,
  input  wire q_sts_t     q_sts,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [5:0]  quads_r, quads_nxt;
  logic [5:0]  line_quads_r;
  logic [3:0]  indent_r;

  logic        accept;
  logic        close;
  logic [1:0]  gcount;
  logic [15:0] hsrc;
  logic [5:0]  q1, lq;

  assign in_stall  = q_sts.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    close = in_data.empty_buffer || in_data.last_byte;
    hsrc  = in_data.empty_buffer ? held_r : {held_r[7:0], in_data.data_byte};
    if (in_data.empty_buffer)                   gcount = fill_r;
    else if (fill_r == 2'd2)                    gcount = 2'd3;
    else if (in_data.last_byte)                 gcount = fill_r + 2'd1;
    else                                        gcount = 2'd0;

    q_cmd.has_group  = (gcount != 2'd0);
    q_cmd.line_break = (quads_r == 6'd0);
    q_cmd.spaces     = (indent_r > INDENT_CAP) ? INDENT_CAP[2:0] : indent_r[2:0];
    q_cmd.nbytes     = gcount;
    q_cmd.close      = close;
    case (gcount)
      2'd3:    q_cmd.triplet = {held_r, in_data.data_byte};
      2'd2:    q_cmd.triplet = {hsrc, 8'h00};
      default: q_cmd.triplet = {hsrc[7:0], 16'h0000};
    endcase
    q_push = accept && (q_cmd.has_group || close);

    lq = (line_quads_r == 6'd0) ? 6'd1 : line_quads_r;
    q1 = quads_r + 6'd1;

    held_nxt  = held_r;
    fill_nxt  = fill_r;
    quads_nxt = quads_r;
    if (accept) begin
      if (close) begin
        held_nxt  = 16'h0000;
        fill_nxt  = 2'd0;
        quads_nxt = 6'd0;
      end else begin
        if (fill_r == 2'd2) begin
          held_nxt = 16'h0000;
          fill_nxt = 2'd0;
        end else begin
          held_nxt = hsrc;
          fill_nxt = fill_r + 2'd1;
        end
        if (q_cmd.has_group) quads_nxt = (q1 >= lq) ? 6'd0 : q1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 16'h0000;
      fill_r       <= 2'd0;
      quads_r      <= 6'd0;
      line_quads_r <= LINE_QUADS_RST;
      indent_r     <= INDENT_SPACES_RST;
    end else begin
      held_r  <= held_nxt;
      fill_r  <= fill_nxt;
      quads_r <= quads_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_QUADS:    line_quads_r <= cfg_data;
          CFG_INDENT_SPACES: indent_r     <= cfg_data[3:0];
          default:           ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/b64e_queue.sv =====
`default_nettype none
module b64e_queue import b64e_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_ctl_t ctl,
  input  wire cmd_t   wr_cmd,
  output cmd_t        rd_cmd,
  output q_sts_t      sts
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign rd_cmd    = mem_r[rptr_r];
  assign sts.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign sts.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (ctl.push) mem_r[wptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (ctl.push) wptr_r <= wptr_r + QPTR_W'(1);
      if (ctl.pop)  rptr_r <= rptr_r + QPTR_W'(1);
      case ({ctl.push, ctl.pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/b64e_back.sv =====
`default_nettype none
module b64e_back import b64e_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cmd_t   q_cmd,
  input  wire q_sts_t q_sts,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data
);

  typedef enum logic [2:0] {
    PH_CR1, PH_LF1, PH_SP, PH_Q, PH_CR2, PH_LF2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       busy_r, busy_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [1:0] qidx_r, qidx_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic       can_emit, emit, last_char;
  logic [5:0] sext;
  logic [7:0] cur_char;

  function automatic phase_t first_phase(input cmd_t c);
    phase_t p;
    if (c.has_group && c.line_break) p = PH_CR1;
    else if (c.has_group)            p = PH_Q;
    else                             p = PH_CR2;
    return p;
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (qidx_r)
      2'd0:    sext = cmd_r.triplet[23:18];
      2'd1:    sext = cmd_r.triplet[17:12];
      2'd2:    sext = cmd_r.triplet[11:6];
      default: sext = cmd_r.triplet[5:0];
    endcase

    unique case (phase_r)
      PH_CR1, PH_CR2: cur_char = CHAR_CR;
      PH_LF1, PH_LF2: cur_char = CHAR_LF;
      PH_SP:          cur_char = CHAR_SPACE;
      default:        cur_char = (qidx_r <= cmd_r.nbytes) ? sextet_char(sext) : CHAR_PAD;
    endcase

    can_emit  = !out_valid_r || !out_stall;
    emit      = busy_r && can_emit;
    last_char = (phase_r == PH_LF2) ||
                (phase_r == PH_Q && qidx_r == 2'd3 && !cmd_r.close);
    q_pop     = !q_sts.empty && (!busy_r || (emit && last_char));

    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    cmd_nxt   = cmd_r;
    qidx_nxt  = qidx_r;
    cnt_nxt   = cnt_r;
    if (q_pop) begin
      cmd_nxt   = q_cmd;
      phase_nxt = first_phase(q_cmd);
      qidx_nxt  = 2'd0;
      cnt_nxt   = q_cmd.spaces;
      busy_nxt  = 1'b1;
    end else if (emit) begin
      if (last_char) begin
        busy_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_CR1: phase_nxt = PH_LF1;
          PH_LF1: phase_nxt = (cnt_r != 3'd0) ? PH_SP : PH_Q;
          PH_SP: begin
            cnt_nxt = cnt_r - 3'd1;
            if (cnt_r == 3'd1) phase_nxt = PH_Q;
          end
          PH_Q: begin
            if (qidx_r == 2'd3) phase_nxt = PH_CR2;
            else                qidx_nxt  = qidx_r + 2'd1;
          end
          PH_CR2:  phase_nxt = PH_LF2;
          default: phase_nxt = PH_LF2;
        endcase
      end
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (can_emit) begin
      out_valid_nxt            = busy_r;
      out_data_nxt.out_char    = cur_char;
      out_data_nxt.end_of_text = (phase_r == PH_LF2);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    qidx_r     <= qidx_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      phase_r     <= PH_CR1;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/base64_encoder_line_wrapped.sv =====
// Channel  Handshake               Payload
// in_      in_valid / in_stall     in_data   (in_item_t)
// out_     out_valid / out_stall   out_data  (out_item_t)
// cfg_     cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Output rate is one character per cycle unless stalled, set by the back-end
// sequencer; a byte yields 0 to 12 characters, about 1.33 on average plus
// line breaks. Requests pass the queue, cmd_r and out_data_r before output.
// Reset (synchronous, rst_n low) empties the queue and resets control state.
// in_stall rises only when the 4-entry request queue is full.
`default_nettype none
module base64_encoder_line_wrapped import b64e_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data
);

  q_ctl_t q_ctl;
  q_sts_t q_sts;
  cmd_t   wr_cmd, rd_cmd;

  b64e_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_sts, .q_push(q_ctl.push), .q_cmd(wr_cmd)
  );

  b64e_queue u_queue (
    .clk, .rst_n, .ctl(q_ctl), .wr_cmd, .rd_cmd, .sts(q_sts)
  );

  b64e_back u_back (
    .clk, .rst_n, .q_cmd(rd_cmd), .q_sts, .q_pop(q_ctl.pop),
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

// ===== src/b64e_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module b64e_checker import b64e_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `CHK_RESET(a_rst_quiet, clk, !rst_n, !out_valid)
  `CHK_ALWAYS(a_eot_lf, clk, rst_n, !(out_valid && out_data.end_of_text) || out_data.out_char == CHAR_LF)
  `CHK_NEXT(a_cr_then_lf, clk, rst_n, out_valid && !out_stall && out_data.out_char == CHAR_CR, out_valid && out_data.out_char == CHAR_LF)

endmodule

bind base64_encoder_line_wrapped b64e_checker u_b64e_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
`default_nettype wire
